### rtl/ymrc_pkg.sv
// shared types, codes and helper functions for the ymodem receiver control block
package ymrc_pkg;

	localparam int LEN_W   = 11;
	localparam int BLK_W   = 32;
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int IDX_W   = 3;

	localparam logic [LEN_W-1:0] LONG_FRAME_LEN = 11'd1029;
	localparam logic [LEN_W-1:0] CRC_MIN_LEN    = 11'd100;
	localparam logic [LEN_W-1:0] LEN_MAX        = 11'd2047;
	localparam logic [LEN_W-1:0] HDR_OVERHEAD   = 11'd5;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [BLK_W-1:0] HDR_FLAG = 32'h8000_0000;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;
	localparam logic [7:0] CH_NONE = 8'h00;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam logic [1:0] EP_NONE  = 2'd0;
	localparam logic [1:0] EP_FIRST = 2'd1;
	localparam logic [1:0] EP_DONE  = 2'd2;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_START,
		PS_XFER,
		PS_EOT,
		PS_NEXT,
		PS_FIN
	} proto_state_t;

	typedef enum logic [1:0] {
		RK_FRAME,
		RK_ONE,
		RK_TWO,
		RK_FINAL
	} rkind_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       frame_end;
		logic       start_req;
		logic       timeout;
	} in_word_t;

	typedef struct packed {
		logic             tx_valid;
		logic [7:0]       tx_byte;
		logic             frame_checked;
		logic [LEN_W-1:0] payload_len;
		logic             update_done;
		logic [30:0]      block_count;
		logic             header_seen;
		logic             result_last;
	} out_word_t;

	// one queued job for the back end
	typedef struct packed {
		rkind_t           kind;
		logic [7:0]       rbyte;
		logic [LEN_W-1:0] plen;
		logic [BLK_W-1:0] blocks;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] last_idx(input rkind_t kind);
		logic [IDX_W-1:0] r;
		unique case (kind)
			RK_FRAME: r = 3'd0;
			RK_ONE:   r = 3'd0;
			RK_TWO:   r = 3'd1;
			RK_FINAL: r = 3'd5;
			default:  r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/ymodem_receiver_control.sv
// top level of the ymodem receiver control block
//
//   channel   handshake     payload     word
//   input     push / full   item        frame byte or poll
//   output    pop / empty   result      reply byte or frame verdict
//
// one input word per cycle while full is low; the front end updates all protocol state in that cycle
// a result word leaves the output register each cycle that pop is high; a poll that ends the
// transfer expands to six words and holds the back end until all six have left
// full rises when the four-entry job queue is full; reset clears all control state
module ymodem_receiver_control (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ymrc_pkg::in_word_t  item,
	output logic                empty,
	input  logic                pop,
	output ymrc_pkg::out_word_t result
);
	import ymrc_pkg::*;

	logic   acc;
	logic   q_push;
	logic   q_pop;
	qent_t  q_wdata;
	qent_t  q_head;
	qstat_t q_stat;

	assign full = q_stat.full;
	assign acc  = push && !q_stat.full;

	ymrc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (item),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	ymrc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.stat    (q_stat)
	);

	ymrc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.head_vld (!q_stat.empty),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

### rtl/ymrc_queue.sv
// short job queue between the front end and the back end
module ymrc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  ymrc_pkg::qent_t wr_data,
	input  logic           rd_en,
	output ymrc_pkg::qent_t rd_data,
	output ymrc_pkg::qstat_t stat
);
	import ymrc_pkg::*;

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign stat.full  = (cnt_q == QDEPTH[QAW:0]);
	assign stat.empty = (cnt_q == '0);
	assign do_wr = wr_en && !stat.full;
	assign do_rd = rd_en && !stat.empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

### rtl/ymrc_front.sv
// front end: frame accumulation, crc, frame judgement and reply machine
module ymrc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  ymrc_pkg::in_word_t item,
	output logic              q_push,
	output ymrc_pkg::qent_t   q_data
);
	import ymrc_pkg::*;

	proto_state_t     state_q, state_d;
	logic [7:0]       pend_q, pend_d;
	logic [1:0]       endp_q, endp_d;
	logic [BLK_W-1:0] blocks_q, blocks_d;
	logic [BLK_W-1:0] short_q, short_d;
	logic [15:0]      crc_q, crc_d;
	logic [15:0]      tail_q, tail_d;
	logic [7:0]       hdr_q, hdr_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [15:0]      calc;
	logic             emit;
	qent_t            ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PS_IDLE;
			pend_q   <= CH_NONE;
			endp_q   <= EP_NONE;
			blocks_q <= '0;
			short_q  <= '0;
			crc_q    <= '0;
			tail_q   <= '0;
			hdr_q    <= '0;
			len_q    <= '0;
		end else begin
			state_q  <= state_d;
			pend_q   <= pend_d;
			endp_q   <= endp_d;
			blocks_q <= blocks_d;
			short_q  <= short_d;
			crc_q    <= crc_d;
			tail_q   <= tail_d;
			hdr_q    <= hdr_d;
			len_q    <= len_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		endp_d   = endp_q;
		blocks_d = blocks_q;
		short_d  = short_q;
		crc_d    = crc_q;
		tail_d   = tail_q;
		hdr_d    = hdr_q;
		len_d    = len_q;
		calc     = '0;
		emit     = 1'b0;
		ent.kind  = RK_FRAME;
		ent.rbyte = CH_NONE;
		ent.plen  = '0;
		if (acc) begin
			if (item.cmd == CMD_BYTE) begin
				if (len_q == '0) hdr_d = item.rx_byte;
				// crc trails the input by two bytes so the check word is never folded in
				if (len_q >= HDR_OVERHEAD) crc_d = crc_byte(crc_q, tail_q[15:8]);
				tail_d = {tail_q[7:0], item.rx_byte};
				if (len_q != LEN_MAX) len_d = len_q + 1'b1;
				if (item.frame_end) begin
					emit = 1'b1;
					ent.kind = RK_FRAME;
					if (state_q != PS_IDLE) begin
						if (len_d > CRC_MIN_LEN) calc = crc_d;
						if (calc == tail_d && (hdr_d == CH_STX || hdr_d == CH_SOH)) begin
							pend_d = CH_ACK;
							if (endp_q == EP_NONE) begin
								if (blocks_q == '0) begin
									blocks_d = blocks_q | HDR_FLAG;
								end else begin
									if (len_d == LONG_FRAME_LEN) begin
										blocks_d = blocks_q + 1'b1;
									end else begin
										if (short_q == '0) blocks_d = blocks_q + 1'b1;
										short_d = short_q + 1'b1;
									end
									ent.plen = (len_d >= HDR_OVERHEAD) ? len_d - HDR_OVERHEAD : '0;
								end
							end
						end else if (hdr_d == CH_EOT) begin
							if (endp_q == EP_NONE) begin
								endp_d = EP_FIRST;
								pend_d = CH_NAK;
							end else begin
								endp_d   = EP_DONE;
								blocks_d = '0;
								short_d  = '0;
								pend_d   = CH_ACK;
							end
						end else begin
							pend_d = CH_NAK;
						end
					end
					crc_d  = '0;
					tail_d = '0;
					hdr_d  = '0;
					len_d  = '0;
				end
			end else begin
				unique case (state_q)
					PS_IDLE: begin
						if (item.start_req) state_d = PS_START;
					end
					PS_START: begin
						if (pend_q != CH_NONE) begin
							emit = 1'b1;
							ent.kind = RK_TWO;
							ent.rbyte = pend_q;
							state_d = PS_XFER;
						end else if (item.timeout) begin
							emit = 1'b1;
							ent.kind = RK_ONE;
							ent.rbyte = CH_C;
						end
					end
					PS_XFER: begin
						if (pend_q != CH_NONE) begin
							emit = 1'b1;
							ent.kind = RK_ONE;
							ent.rbyte = pend_q;
							if (pend_q == CH_NAK && endp_q == EP_FIRST) state_d = PS_EOT;
						end
					end
					PS_EOT: begin
						if (pend_q != CH_NONE) begin
							emit = 1'b1;
							ent.kind = RK_ONE;
							ent.rbyte = pend_q;
							if (pend_q == CH_ACK && endp_q == EP_DONE) state_d = PS_NEXT;
						end
					end
					PS_NEXT: begin
						emit = 1'b1;
						ent.kind = RK_ONE;
						ent.rbyte = CH_C;
						state_d = PS_FIN;
					end
					PS_FIN: begin
						if (pend_q == CH_ACK) begin
							emit = 1'b1;
							ent.kind = RK_FINAL;
							endp_d = EP_NONE;
							state_d = PS_IDLE;
						end
					end
					default: begin
						state_d = state_q;
					end
				endcase
				pend_d = CH_NONE;
			end
		end
		ent.blocks = blocks_d;
	end

	assign q_push = emit;
	assign q_data = ent;

endmodule

### rtl/ymrc_back.sv
// back end: expands queued jobs into result words, one per cycle while the output is empty or popped
module ymrc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ymrc_pkg::qent_t     head,
	input  logic                head_vld,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output ymrc_pkg::out_word_t result
);
	import ymrc_pkg::*;

	out_word_t        out_q;
	logic             out_vld_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last;
	logic             load;
	out_word_t        w;

	assign load  = !out_vld_q || pop;
	assign last  = last_idx(head.kind);
	assign q_pop = load && head_vld && (idx_q == last);
	assign empty = !out_vld_q;
	assign result = out_q;

	always_comb begin
		w = '0;
		w.block_count = head.blocks[30:0];
		w.header_seen = head.blocks[31];
		w.result_last = (idx_q == last);
		unique case (head.kind)
			RK_FRAME: begin
				w.frame_checked = 1'b1;
				w.payload_len   = head.plen;
			end
			RK_ONE: begin
				w.tx_valid = 1'b1;
				w.tx_byte  = head.rbyte;
			end
			RK_TWO: begin
				w.tx_valid = 1'b1;
				w.tx_byte  = (idx_q == '0) ? head.rbyte : CH_C;
			end
			RK_FINAL: begin
				w.tx_valid    = 1'b1;
				w.update_done = 1'b1;
				w.tx_byte     = (idx_q == '0) ? CH_ACK : CH_CAN;
			end
			default: begin
				w.tx_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (load) begin
			out_vld_q <= head_vld;
			if (head_vld) idx_q <= (idx_q == last) ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_vld) out_q <= w;
	end

endmodule

### rtl/ymrc_checker.sv
// port-level checks for the ymodem receiver control block, bound to the top level
module ymrc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input ymrc_pkg::out_word_t result
);
	import ymrc_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result word changed while stalled");

	// a frame verdict sends nothing and closes its input
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.frame_checked |-> !result.tx_valid && result.result_last
			&& result.tx_byte == CH_NONE && !result.update_done)
		else $error("malformed frame verdict word");

	// only frame verdicts carry a payload length
	a_plen: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.payload_len != '0 |-> result.frame_checked)
		else $error("payload length on a reply word");

	// the closing sequence continues with cancel bytes
	a_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.update_done && !result.result_last) ##1 !empty
			|-> result.update_done && result.tx_byte == CH_CAN)
		else $error("closing sequence broken");

endmodule

bind ymodem_receiver_control ymrc_checker u_ymrc_checker (.*);
